/* design/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, sampled on clk_i with rst_ni low disabling checks
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed: implication");

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

/* design/escd_pkg.sv */
// ---------------------------------------------------------------------------
// escd_pkg
// widths, constants and the soft clip curve table of the waveshaper
// ---------------------------------------------------------------------------
package escd_pkg;

  // curve table geometry
  localparam int CURVE_TABLE_ENTRIES = 256;
  localparam int CURVE_INPUT_LIMIT   = 16;

  // sample and gain widths
  localparam int SAMPLE_W   = 16;
  localparam int MAG_W      = SAMPLE_W + 1;
  localparam int GAIN_W     = 10;
  localparam int GAIN_RESET = 160;
  localparam int GAIN_SHIFT = 3;                 // Q15 x Q6.4 -> Q16
  localparam int PROD_W     = MAG_W + GAIN_W;
  localparam int U_W        = PROD_W - GAIN_SHIFT;

  // table index and interpolation fraction
  localparam int SPAN    = CURVE_INPUT_LIMIT * (2 ** 16);
  localparam int FRAC_W  = $clog2(SPAN);
  localparam int TIDX_W  = $clog2(CURVE_TABLE_ENTRIES + 1);
  localparam int P_W     = U_W + TIDX_W;

  // curve values in Q30, with room for 1.0
  localparam int Q_BITS     = 30;
  localparam int G_W        = Q_BITS + 1;
  localparam int FULL_SCALE = 32767;
  localparam logic [G_W-1:0] ONE_Q30 = G_W'(64'd1 << Q_BITS);

  // step of the curve input between two table points, Q30
  localparam logic [63:0] DQ = (64'(CURVE_INPUT_LIMIT) << Q_BITS) / CURVE_TABLE_ENTRIES;

  typedef logic [G_W-1:0] curve_t [0:CURVE_TABLE_ENTRIES];

  // interpolation operands for one beat
  typedef struct packed {
    logic [G_W-1:0]    lo;
    logic [G_W-1:0]    diff;
    logic [FRAC_W-1:0] frac;
  } interp_t;

  // shift-subtract long division, used at elaboration only
  function automatic logic [63:0] div_floor(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    int          i;
    rem = '0;
    quo = '0;
    for (i = 63; i >= 0; i--) begin
      rem = {rem[63:0], num[i]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[i] = 1'b1;
      end
    end
    return quo;
  endfunction

  // points of 1 - exp(-k*d) in Q30, built by repeated multiplication with exp(-d)
  function automatic curve_t build_curve();
    curve_t      tbl;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] r;
    logic [63:0] e;
    logic [63:0] one;
    int          n;
    int          k;
    one  = 64'd1 << Q_BITS;
    term = one;
    sum  = one;
    e    = one;
    // taylor sum of exp(d), each term truncated
    for (n = 1; n < 64; n++) begin
      if (term != 64'd0) begin
        term = (term * DQ) >> Q_BITS;
        term = div_floor(term, 64'(n));
        sum  = sum + term;
      end
    end
    // exp(-d) as the rounded reciprocal
    r = div_floor((64'd1 << 60) + (sum >> 1), sum);
    if (r > one) begin
      r = one;
    end
    tbl[0] = '0;
    for (k = 1; k <= CURVE_TABLE_ENTRIES; k++) begin
      e      = (e * r + (one >> 1)) >> Q_BITS;
      tbl[k] = G_W'(32'(one - e));
    end
    return tbl;
  endfunction

  localparam curve_t CURVE_TABLE = build_curve();

endpackage

/* design/escd_lookup.sv */
// ---------------------------------------------------------------------------
// escd_lookup
// splits the scaled magnitude into table index and fraction and reads the
// two neighbouring curve points
// ---------------------------------------------------------------------------
module escd_lookup import escd_pkg::*; (
  input  logic [U_W-1:0] u_i,
  output interp_t        interp_o
);

  logic [P_W-1:0]    p;
  logic [P_W-1:0]    idx_full;
  logic [P_W-1:0]    frac_full;
  logic              sat;
  logic [TIDX_W-1:0] idx;
  logic [TIDX_W-1:0] idx_nx;
  logic [G_W-1:0]    lo;
  logic [G_W-1:0]    hi;

  // position on the curve axis
  assign p         = P_W'(u_i) * P_W'(CURVE_TABLE_ENTRIES);
  assign idx_full  = p / P_W'(SPAN);
  assign frac_full = p % P_W'(SPAN);
  assign sat       = idx_full >= P_W'(CURVE_TABLE_ENTRIES);

  // keep the index inside the table when saturated
  assign idx    = sat ? '0 : idx_full[TIDX_W-1:0];
  assign idx_nx = idx + TIDX_W'(1);
  assign lo     = CURVE_TABLE[idx];
  assign hi     = CURVE_TABLE[idx_nx];

  // past the end the curve sits at full scale
  always_comb begin
    if (sat) begin
      interp_o.lo   = ONE_Q30;
      interp_o.diff = '0;
      interp_o.frac = '0;
    end else begin
      interp_o.lo   = lo;
      interp_o.diff = (hi >= lo) ? hi - lo : '0;
      interp_o.frac = frac_full[FRAC_W-1:0];
    end
  end

endmodule

/* design/exponential_soft_clip_distortion.sv */
// ---------------------------------------------------------------------------
// exponential_soft_clip_distortion
// exponential soft clip waveshaper for signed 16-bit audio samples
// ---------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with in_sample_i; a beat is taken
// when valid is high and stall is low. Output channel: out_valid_o /
// out_stall_i with out_sample_o, same rule.
// drive_gain_i (unsigned Q6.4) is written whenever drive_gain_we_i is high;
// change it only while no samples are in flight.
// Four register stages: gain multiply, curve table read, interpolation
// multiply, full-scale multiply with sign. A sample passes them in that
// order and reaches the output register before the receiver can take it.
// One sample per cycle is accepted and delivered while the receiver does
// not stall; the rate is set by the four-stage pipeline with no loop.
// Out of reset the pipeline is empty and the drive gain is 10.0.
// When the receiver stalls, the output beat holds and the stages behind it
// keep filling bubbles; the input stalls only once all four stages are full.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module exponential_soft_clip_distortion import escd_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       drive_gain_we_i,
  input  logic [GAIN_W-1:0]          drive_gain_i,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic signed [SAMPLE_W-1:0] in_sample_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [SAMPLE_W-1:0] out_sample_o
);

  localparam int MUL3_W = G_W + FRAC_W;
  localparam int MUL4_W = G_W + SAMPLE_W;

  logic [GAIN_W-1:0] drive_gain_q;

  logic              s1_valid_q;
  logic              s1_neg_q;
  logic [U_W-1:0]    s1_u_q;
  logic              s2_valid_q;
  logic              s2_neg_q;
  interp_t           s2_interp_q;
  logic              s3_valid_q;
  logic              s3_neg_q;
  logic [G_W-1:0]    s3_g_q;
  logic              out_valid_q;
  logic [SAMPLE_W-1:0] out_sample_q;

  logic              s1_rdy;
  logic              s2_rdy;
  logic              s3_rdy;
  logic              out_rdy;

  logic [SAMPLE_W-1:0] raw;
  logic [MAG_W-1:0]  mag;
  logic [PROD_W-1:0] prod1;
  logic [U_W-1:0]    s1_u_d;
  interp_t           s2_interp_d;
  logic [MUL3_W-1:0] prod3;
  logic [G_W-1:0]    s3_g_d;
  logic [MUL4_W-1:0] prod4;
  logic [SAMPLE_W-1:0] m_full;
  logic [SAMPLE_W-1:0] m_sat;
  logic [SAMPLE_W-1:0] out_sample_d;

  // drive gain register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_gain_q <= GAIN_W'(GAIN_RESET);
    end else if (drive_gain_we_i) begin
      drive_gain_q <= drive_gain_i;
    end
  end

  // stage ready chain, a stage moves when it is empty or its successor moves
  assign out_rdy    = !out_valid_q || !out_stall_i;
  assign s3_rdy     = !s3_valid_q || out_rdy;
  assign s2_rdy     = !s2_valid_q || s3_rdy;
  assign s1_rdy     = !s1_valid_q || s2_rdy;
  assign in_stall_o = !s1_rdy;

  // stage 1: magnitude times drive gain
  assign raw    = in_sample_i;
  assign mag    = raw[SAMPLE_W-1] ? (MAG_W'(1) << SAMPLE_W) - MAG_W'(raw) : MAG_W'(raw);
  assign prod1  = PROD_W'(mag) * PROD_W'(drive_gain_q);
  assign s1_u_d = U_W'(prod1 >> GAIN_SHIFT);

  // stage 2: curve table read
  escd_lookup u_lookup (
    .u_i      (s1_u_q),
    .interp_o (s2_interp_d)
  );

  // stage 3: linear interpolation between the two points
  assign prod3  = MUL3_W'(s2_interp_q.diff) * MUL3_W'(s2_interp_q.frac);
  assign s3_g_d = s2_interp_q.lo + G_W'(prod3 / MUL3_W'(SPAN));

  // stage 4: scale to full scale, clamp and apply the sign
  assign prod4  = MUL4_W'(s3_g_q) * MUL4_W'(FULL_SCALE);
  assign m_full = SAMPLE_W'(prod4 >> Q_BITS);
  assign m_sat  = (m_full > SAMPLE_W'(FULL_SCALE)) ? SAMPLE_W'(FULL_SCALE) : m_full;
  assign out_sample_d = s3_neg_q ? SAMPLE_W'(0) - m_sat : m_sat;

  // valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      s3_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_rdy) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_rdy) begin
        s2_valid_q <= s1_valid_q;
      end
      if (s3_rdy) begin
        s3_valid_q <= s2_valid_q;
      end
      if (out_rdy) begin
        out_valid_q <= s3_valid_q;
      end
    end
  end

  // payload registers, loaded when a beat moves in
  always_ff @(posedge clk_i) begin
    if (s1_rdy && in_valid_i) begin
      s1_neg_q <= raw[SAMPLE_W-1];
      s1_u_q   <= s1_u_d;
    end
    if (s2_rdy && s1_valid_q) begin
      s2_neg_q    <= s1_neg_q;
      s2_interp_q <= s2_interp_d;
    end
    if (s3_rdy && s2_valid_q) begin
      s3_neg_q <= s2_neg_q;
      s3_g_q   <= s3_g_d;
    end
    if (out_rdy && s3_valid_q) begin
      out_sample_q <= out_sample_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_sample_o = out_sample_q;

  // input only stalls with every stage occupied
  `ASSERT_IMPLIES(a_stall_full, in_stall_o,
                  s1_valid_q && s2_valid_q && s3_valid_q && out_valid_q)
  // interpolated curve never passes 1.0
  `ASSERT_IMPLIES(a_curve_bound, s3_valid_q, s3_g_q <= ONE_Q30)
  // magnitude is capped at full scale, so the most negative code never shows
  `ASSERT_IMPLIES(a_out_range, out_valid_o, out_sample_o != 16'sh8000)

endmodule
